### rtl/second_order_lowpass_biquad_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the low-pass biquad
// Clocked implication checks, both disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef SECOND_ORDER_LOWPASS_BIQUAD_CORE_ASSERT_SVH
`define SECOND_ORDER_LOWPASS_BIQUAD_CORE_ASSERT_SVH

// same-cycle implication
`define SOLBQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("biquad check failed");

// next-cycle implication
`define SOLBQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("biquad check failed");

`endif

### rtl/solbq_pkg.sv
// ----------------------------------------------------------------------------
// solbq_pkg
// Widths, types and codes shared by the low-pass biquad.
// ----------------------------------------------------------------------------
package solbq_pkg;

   localparam int SAMPLE_WIDTH   = 16;
   localparam int COEF_WIDTH     = 20;
   localparam int COEF_FRAC_BITS = 16;

   // five products of SAMPLE x COEF bits, plus growth for the sum and rounding
   localparam int ACC_WIDTH   = SAMPLE_WIDTH + COEF_WIDTH + 3;
   localparam int QUANT_WIDTH = ACC_WIDTH - COEF_FRAC_BITS;

   localparam int CSR_INDEX_WIDTH = 3;

   typedef logic signed [SAMPLE_WIDTH-1:0]    sample_type;
   typedef logic signed [COEF_WIDTH-1:0]      coef_type;
   typedef logic signed [ACC_WIDTH-1:0]       acc_type;
   typedef logic signed [QUANT_WIDTH-1:0]     quant_type;
   typedef logic        [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam csr_index_type CSR_B0 = csr_index_type'(0);
   localparam csr_index_type CSR_B1 = csr_index_type'(1);
   localparam csr_index_type CSR_B2 = csr_index_type'(2);
   localparam csr_index_type CSR_A1 = csr_index_type'(3);
   localparam csr_index_type CSR_A2 = csr_index_type'(4);

   localparam coef_type COEF_ONE = coef_type'(1) <<< COEF_FRAC_BITS;

   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   localparam acc_type ROUND_HALF = acc_type'(1) <<< (COEF_FRAC_BITS - 1);

   // warm-up progress: how many histories have been primed
   typedef enum logic [1:0] {
      WARM_EMPTY = 2'd0,
      WARM_ONE   = 2'd1,
      WARM_FULL  = 2'd2
   } warm_state_type;

endpackage

### rtl/second_order_lowpass_biquad_core.sv
// ----------------------------------------------------------------------------
// second_order_lowpass_biquad_core: direct form I low-pass biquad, Q3.16 taps
// Input register, then result register; one word per cycle unless the consumer
// stalls, set by the combinational multiply/sum/saturate pass closing y1 feedback.
// Synchronous reset: coefficients to pass-through (b0 = 1.0), histories clear.
// ----------------------------------------------------------------------------
`include "second_order_lowpass_biquad_core_assert.svh"

module second_order_lowpass_biquad_core (
   input  logic                     clock,
   input  logic                     reset,
   // input sample channel
   input  logic                     req_valid,
   output logic                     req_ready,
   input  solbq_pkg::sample_type    req_sample_in,
   // filtered sample channel
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output solbq_pkg::sample_type    rsp_sample_out,
   output logic                     rsp_clipped,
   // coefficient write port
   input  logic                     csr_we,
   input  solbq_pkg::csr_index_type csr_index,
   input  solbq_pkg::coef_type      csr_wdata
);
   import solbq_pkg::*;

   // ------------------------------------------------------------------------
   // Coefficient registers. A write to a known index also restarts warm-up.
   // ------------------------------------------------------------------------
   coef_type b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;
   logic     csr_hit;

   always_comb begin
      case (csr_index)
         CSR_B0, CSR_B1, CSR_B2, CSR_A1, CSR_A2: csr_hit = csr_we;
         default: csr_hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_ff <= COEF_ONE;
         b1_ff <= '0;
         b2_ff <= '0;
         a1_ff <= '0;
         a2_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_B0: b0_ff <= csr_wdata;
            CSR_B1: b1_ff <= csr_wdata;
            CSR_B2: b2_ff <= csr_wdata;
            CSR_A1: a1_ff <= csr_wdata;
            CSR_A2: a2_ff <= csr_wdata;
            default: ;   // unknown index: drop the write
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Handshake. Input register feeds the arithmetic pass; the result register
   // decouples the output side so a new word can enter while a result waits.
   // ------------------------------------------------------------------------
   logic       in_valid_ff,  in_valid_in;
   sample_type x_ff;
   logic       out_valid_ff, out_valid_in;
   sample_type out_sample_ff;
   logic       out_clip_ff;
   logic       advance;

   // move the held word into the result register this cycle
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // capture payload only on acceptance; hold otherwise
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         x_ff <= req_sample_in;
      end
   end

   // ------------------------------------------------------------------------
   // Warm-up sequencer: first word primes x2/y2, second primes x1/y1, then
   // the filter runs. A coefficient write restarts it.
   // ------------------------------------------------------------------------
   warm_state_type warm_ff, warm_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         warm_ff <= WARM_EMPTY;
      end else begin
         warm_ff <= warm_in;
      end
   end

   always_comb begin
      warm_in = warm_ff;
      if (csr_hit) begin
         warm_in = WARM_EMPTY;
      end else if (advance) begin
         case (warm_ff)
            WARM_EMPTY: warm_in = WARM_ONE;
            WARM_ONE:   warm_in = WARM_FULL;
            WARM_FULL:  warm_in = WARM_FULL;
            default:    warm_in = WARM_EMPTY;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Single-pass arithmetic: five products, sum, round half up, saturate, warm-up bypass.
   // ------------------------------------------------------------------------
   sample_type x1_ff, x2_ff, y1_ff, y2_ff;
   acc_type    acc_sum;
   acc_type    acc_round;
   quant_type  quant;
   sample_type filt_y;
   logic       filt_clip;
   sample_type y_res;
   logic       clip_res;

   always_comb begin
      acc_sum = (acc_type'(b0_ff) * acc_type'(x_ff))
              + (acc_type'(b1_ff) * acc_type'(x1_ff))
              + (acc_type'(b2_ff) * acc_type'(x2_ff))
              + (acc_type'(a1_ff) * acc_type'(y1_ff))
              + (acc_type'(a2_ff) * acc_type'(y2_ff));
      acc_round = acc_sum + ROUND_HALF;
      // arithmetic shift floors, giving ties toward plus infinity
      quant = quant_type'(acc_round >>> COEF_FRAC_BITS);

      if (quant > quant_type'(SAMPLE_MAX)) begin
         filt_y    = SAMPLE_MAX;
         filt_clip = 1'b1;
      end else if (quant < quant_type'(SAMPLE_MIN)) begin
         filt_y    = SAMPLE_MIN;
         filt_clip = 1'b1;
      end else begin
         filt_y    = sample_type'(quant);
         filt_clip = 1'b0;
      end

      // warm-up words pass straight through
      if (warm_ff == WARM_FULL) begin
         y_res    = filt_y;
         clip_res = filt_clip;
      end else begin
         y_res    = x_ff;
         clip_res = 1'b0;
      end
   end

   // ------------------------------------------------------------------------
   // Histories: shift on a filtered word, prime on warm-up words, clear on a
   // coefficient write.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset || csr_hit) begin
         x1_ff <= '0;
         x2_ff <= '0;
         y1_ff <= '0;
         y2_ff <= '0;
      end else if (advance) begin
         case (warm_ff)
            WARM_EMPTY: begin
               x2_ff <= x_ff;
               y2_ff <= x_ff;
            end
            WARM_ONE: begin
               x1_ff <= x_ff;
               y1_ff <= x_ff;
            end
            default: begin
               x2_ff <= x1_ff;
               x1_ff <= x_ff;
               y2_ff <= y1_ff;
               y1_ff <= y_res;
            end
         endcase
      end
   end

   // result register: load on advance, hold while the consumer stalls
   always_ff @(posedge clock) begin
      if (advance) begin
         out_sample_ff <= y_res;
         out_clip_ff   <= clip_res;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_sample_out = out_sample_ff;
   assign rsp_clipped    = out_clip_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   // a clipped result sits on one of the rails
   `SOLBQ_ASSERT_NOW(a_clip_on_rail, clock, reset, rsp_valid && rsp_clipped, (rsp_sample_out == SAMPLE_MAX) || (rsp_sample_out == SAMPLE_MIN))
   // warm-up words never report saturation
   `SOLBQ_ASSERT_NEXT(a_warm_no_clip, clock, reset, advance && (warm_ff != WARM_FULL), !out_clip_ff)
   // a coefficient write restarts warm-up and empties the histories
   `SOLBQ_ASSERT_NEXT(a_csr_restart, clock, reset, csr_hit, (warm_ff == WARM_EMPTY) && (y1_ff == '0) && (x1_ff == '0))
   // a word moved forward always shows up as a valid result
   `SOLBQ_ASSERT_NEXT(a_advance_fills, clock, reset, advance, out_valid_ff)

endmodule
